// File: rtl/core/ltt_pkg.sv
// Shared constants, codes and control types for the long interval tick timer.
package ltt_pkg;

  localparam int COUNTER_BITS_DEF = 24;

  localparam int CMD_W      = 3;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 24;
  localparam int CLOCK_W    = 27;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;

  localparam int DIV_W      = 32;
  localparam int DIV_CNT_W  = 5;
  localparam int P_W        = 18;

  localparam int MS_PER_S       = 1000;
  localparam int PRESCALE_SHIFT = 3;

  // ceil(2^37 / 1000): multiply and shift gives floor(x / 1000) exactly for any 27-bit x
  localparam int RECIP_W      = 28;
  localparam int RECIP_SHIFT  = 37;
  localparam int RECIP_PROD_W = CLOCK_W + RECIP_W;
  localparam logic [RECIP_W-1:0] MS_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S));

  localparam logic [CLOCK_W-1:0] CLOCK_HZ_RST = CLOCK_W'(16000000);

  typedef enum logic [CMD_W-1:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_POLL  = 3'd4
  } ltt_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOCK_HZ  = 2'd0,
    REG_CLOCK_SEL = 2'd1,
    REG_IRQ_EN    = 2'd2
  } ltt_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE,
    ST_DIV_M,
    ST_DIV_Q,
    ST_MUL_FULL,
    ST_MUL_FIRST,
    ST_APPLY
  } ltt_state_t;

  typedef struct packed {
    logic simple;
    logic start_p;
    logic start_m;
    logic latch_m;
    logic start_q;
    logic latch_q;
    logic mul_full;
    logic mul_first;
    logic apply_plan;
    logic apply_halt;
  } ltt_ctl_t;

  typedef struct packed {
    logic out_free;
    logic div_done;
    logic quot_zero;
    logic p_zero;
    logic t_zero;
    logic t_le_m;
  } ltt_sts_t;

endpackage

// File: rtl/core/ltt_if.sv
// Request, result and configuration channel interfaces.
interface ltt_in_if;
  logic                        valid;
  logic                        ready;
  logic [ltt_pkg::CMD_W-1:0]   cmd;
  logic [ltt_pkg::TIME_W-1:0]  time_ms;
  logic [ltt_pkg::COUNT_W-1:0] count_value;

  modport source (output valid, cmd, time_ms, count_value, input ready);
  modport sink   (input valid, cmd, time_ms, count_value, output ready);
endinterface

interface ltt_out_if;
  logic                        valid;
  logic                        ready;
  logic [ltt_pkg::COUNT_W-1:0] current_count;
  logic                        running;
  logic                        wrap_seen;
  logic                        period_done;
  logic                        status;

  modport source (output valid, current_count, running, wrap_seen, period_done, status,
                  input ready);
  modport sink   (input valid, current_count, running, wrap_seen, period_done, status,
                  output ready);
endinterface

interface ltt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ltt_pkg::CFG_IDX_W-1:0]  index;
  logic [ltt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/long_interval_tick_timer.sv
// Long interval tick timer top level.
// Down-counting tick timer that times periods of any 32-bit number of milliseconds by
// chaining counter segments. Tick, stop, write count, poll and spare requests are handled
// directly and may follow back to back; every request returns one result through a
// registered output, and a new request is taken only while that register is empty or
// being read in the same cycle. A start request works out the ticks per ms with a
// reciprocal multiply, then runs the segment limit and, for a long period, the segment
// count and remainder on a bit-serial divider, then two multiplies before the plan is
// applied; it resolves to a stop instead on a zero period or rate, or when the
// segment limit comes out zero. Configuration writes are always taken and belong
// between requests, while no start is in progress.
module long_interval_tick_timer #(
  parameter int COUNTER_BITS = ltt_pkg::COUNTER_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  ltt_in_if.sink    in_req,
  ltt_out_if.source out_res,
  ltt_cfg_if.sink   cfg_wr
);

  ltt_pkg::ltt_ctl_t ctl;
  ltt_pkg::ltt_sts_t sts;
  logic              in_ready;

  assign in_req.ready = in_ready;
  assign cfg_wr.ready = 1'b1;

  ltt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_cmd   (in_req.cmd),
    .sts      (sts),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  ltt_dp #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .in_cmd            (in_req.cmd),
    .in_time_ms        (in_req.time_ms),
    .in_count_value    (in_req.count_value),
    .cfg_we            (cfg_wr.valid),
    .cfg_idx           (cfg_wr.index),
    .cfg_data          (cfg_wr.data),
    .out_ready         (out_res.ready),
    .out_valid         (out_res.valid),
    .out_current_count (out_res.current_count),
    .out_running       (out_res.running),
    .out_wrap_seen     (out_res.wrap_seen),
    .out_period_done   (out_res.period_done),
    .out_status        (out_res.status)
  );

endmodule

// File: rtl/core/ltt_div.sv
// Restoring divider, one quotient bit per cycle.
module ltt_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ltt_pkg::DIV_W-1:0] dividend,
  input  logic [ltt_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [ltt_pkg::DIV_W-1:0] quot,
  output logic [ltt_pkg::DIV_W-1:0] rem
);

  localparam int W = ltt_pkg::DIV_W;

  logic                          busy_r;
  logic                          done_r;
  logic [ltt_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [W-1:0]                  rem_r;
  logic [W-1:0]                  quot_r;
  logic [W-1:0]                  dvs_r;

  logic [W:0]   shifted;
  logic [W:0]   diff;
  logic         ge;
  logic [W-1:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, quot_r[W-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = shifted >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ltt_pkg::DIV_CNT_W'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quot_r <= dividend;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

// File: rtl/core/ltt_ctrl.sv
// Request sequencer: directly handled commands and the multi-step start setup.
module ltt_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [ltt_pkg::CMD_W-1:0] in_cmd,
  input  ltt_pkg::ltt_sts_t         sts,
  output logic                      in_ready,
  output ltt_pkg::ltt_ctl_t         ctl
);

  ltt_pkg::ltt_state_t state_r;
  ltt_pkg::ltt_state_t state_nxt;

  logic accept;
  logic is_start;

  assign in_ready = (state_r == ltt_pkg::ST_IDLE) && sts.out_free;
  assign accept   = in_ready && in_valid;
  assign is_start = in_cmd == ltt_pkg::OP_START;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ltt_pkg::ST_IDLE: begin
        if (accept && is_start) state_nxt = ltt_pkg::ST_RATE;
      end
      ltt_pkg::ST_RATE: begin
        state_nxt = (sts.t_zero || sts.p_zero) ? ltt_pkg::ST_IDLE : ltt_pkg::ST_DIV_M;
      end
      ltt_pkg::ST_DIV_M: begin
        if (sts.div_done) begin
          if (sts.quot_zero)   state_nxt = ltt_pkg::ST_IDLE;
          else if (sts.t_le_m) state_nxt = ltt_pkg::ST_MUL_FULL;
          else                 state_nxt = ltt_pkg::ST_DIV_Q;
        end
      end
      ltt_pkg::ST_DIV_Q: begin
        if (sts.div_done) state_nxt = ltt_pkg::ST_MUL_FULL;
      end
      ltt_pkg::ST_MUL_FULL:  state_nxt = ltt_pkg::ST_MUL_FIRST;
      ltt_pkg::ST_MUL_FIRST: state_nxt = ltt_pkg::ST_APPLY;
      ltt_pkg::ST_APPLY:     state_nxt = ltt_pkg::ST_IDLE;
      default:               state_nxt = ltt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      ltt_pkg::ST_IDLE: begin
        ctl.simple  = accept && !is_start;
        ctl.start_p = accept && is_start;
      end
      ltt_pkg::ST_RATE: begin
        ctl.apply_halt = sts.t_zero || sts.p_zero;
        ctl.start_m    = !(sts.t_zero || sts.p_zero);
      end
      ltt_pkg::ST_DIV_M: begin
        if (sts.div_done) begin
          ctl.apply_halt = sts.quot_zero;
          ctl.latch_m    = !sts.quot_zero;
          ctl.start_q    = !sts.quot_zero && !sts.t_le_m;
        end
      end
      ltt_pkg::ST_DIV_Q: begin
        ctl.latch_q = sts.div_done;
      end
      ltt_pkg::ST_MUL_FULL:  ctl.mul_full   = 1'b1;
      ltt_pkg::ST_MUL_FIRST: ctl.mul_first  = 1'b1;
      ltt_pkg::ST_APPLY:     ctl.apply_plan = 1'b1;
      default:               ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ltt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/ltt_dp.sv
// Timer datapath: counter, segment plan, setup arithmetic, config and result register.
module ltt_dp #(
  parameter int COUNTER_BITS = ltt_pkg::COUNTER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ltt_pkg::ltt_ctl_t              ctl,
  output ltt_pkg::ltt_sts_t              sts,
  input  logic [ltt_pkg::CMD_W-1:0]      in_cmd,
  input  logic [ltt_pkg::TIME_W-1:0]     in_time_ms,
  input  logic [ltt_pkg::COUNT_W-1:0]    in_count_value,
  input  logic                           cfg_we,
  input  logic [ltt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ltt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [ltt_pkg::COUNT_W-1:0]    out_current_count,
  output logic                           out_running,
  output logic                           out_wrap_seen,
  output logic                           out_period_done,
  output logic                           out_status
);

  localparam int CW = COUNTER_BITS;
  localparam int DW = ltt_pkg::DIV_W;
  localparam int PW = ltt_pkg::P_W;
  localparam logic [CW-1:0] CNT_MAX  = '1;
  localparam logic [DW:0]   CMAX_EXT = (DW + 1)'(CNT_MAX);

  // configuration
  logic [ltt_pkg::CLOCK_W-1:0] clock_hz_r;
  logic                        clock_sel_r;
  logic                        irq_en_r;

  // timer state
  logic [CW-1:0] down_r, down_nxt;
  logic          en_r, en_nxt;
  logic          long_r, long_nxt;
  logic [DW-1:0] left_r, left_nxt;
  logic [DW-1:0] total_r, total_nxt;
  logic [CW-1:0] first_r;
  logic [CW-1:0] full_r, full_nxt;
  logic          wrap_r, wrap_nxt;

  // setup working registers
  logic [DW-1:0] t_r;
  logic [PW-1:0] p_r;
  logic [CW-1:0] m_r;
  logic [DW-1:0] q_r;
  logic [CW-1:0] rem_seg_r;
  logic          plan_long_r;

  // result register
  logic                        out_valid_r;
  logic [ltt_pkg::COUNT_W-1:0] count_out_r;
  logic                        running_r;
  logic                        seen_r;
  logic                        done_out_r;
  logic                        bad_r;

  logic                        seen_c;
  logic                        done_c;
  logic                        bad_c;
  logic                        out_load;

  logic                        div_start;
  logic [DW-1:0]               div_dividend;
  logic [DW-1:0]               div_divisor;
  logic                        div_done;
  logic [DW-1:0]               div_quot;
  logic [DW-1:0]               div_rem;

  logic [ltt_pkg::CLOCK_W-1:0]      src_hz;
  logic [ltt_pkg::RECIP_PROD_W-1:0] p_prod;
  logic [PW-1:0]                    p_calc;

  logic [DW-1:0]               mul_a;
  logic [DW+PW-1:0]            prod;

  ltt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // ticks per ms by reciprocal multiply
  always_comb begin
    src_hz = clock_sel_r ? clock_hz_r : (clock_hz_r >> ltt_pkg::PRESCALE_SHIFT);
    p_prod = ltt_pkg::RECIP_PROD_W'(src_hz) * ltt_pkg::RECIP_PROD_W'(ltt_pkg::MS_RECIP);
    p_calc = p_prod[ltt_pkg::RECIP_SHIFT +: PW];
  end

  always_comb begin
    div_start    = ctl.start_m || ctl.start_q;
    div_dividend = DW'(CNT_MAX);
    div_divisor  = DW'(p_r);
    if (ctl.start_q) begin
      div_dividend = t_r;
      div_divisor  = div_quot;
    end
  end

  always_comb begin
    if (ctl.mul_full)          mul_a = DW'(m_r);
    else if (!plan_long_r)     mul_a = t_r;
    else if (rem_seg_r != '0)  mul_a = DW'(rem_seg_r);
    else                       mul_a = DW'(m_r);
    prod = {{PW{1'b0}}, mul_a} * {{DW{1'b0}}, p_r};
  end

  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.div_done  = div_done;
  assign sts.quot_zero = div_quot == '0;
  assign sts.p_zero    = p_r == '0;
  assign sts.t_zero    = t_r == '0;
  assign sts.t_le_m    = t_r <= div_quot;

  always_comb begin
    down_nxt  = down_r;
    en_nxt    = en_r;
    long_nxt  = long_r;
    left_nxt  = left_r;
    total_nxt = total_r;
    full_nxt  = full_r;
    wrap_nxt  = wrap_r;
    done_c    = 1'b0;
    bad_c     = 1'b0;
    if (ctl.simple) begin
      case (ltt_pkg::ltt_op_t'(in_cmd))
        ltt_pkg::OP_TICK: begin
          if (en_r) begin
            if (down_r > CW'(1)) begin
              down_nxt = down_r - 1'b1;
            end else begin
              wrap_nxt = 1'b1;
              if (long_r && left_r != '0) begin
                left_nxt = left_r - 1'b1;
                down_nxt = full_r;
              end else begin
                left_nxt = total_r;
                down_nxt = first_r;
                done_c   = irq_en_r;
              end
            end
          end
        end
        ltt_pkg::OP_STOP: begin
          en_nxt   = 1'b0;
          down_nxt = '0;
          wrap_nxt = 1'b0;
        end
        ltt_pkg::OP_WRITE: begin
          if ((DW + 1)'(in_count_value) > CMAX_EXT) bad_c = 1'b1;
          else down_nxt = CW'(in_count_value);
          wrap_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (ctl.apply_halt) begin
      en_nxt   = 1'b0;
      down_nxt = '0;
      wrap_nxt = 1'b0;
    end else if (ctl.apply_plan) begin
      long_nxt = plan_long_r;
      if (!plan_long_r)            total_nxt = '0;
      else if (rem_seg_r != '0)    total_nxt = q_r;
      else                         total_nxt = q_r - 1'b1;
      left_nxt = total_nxt;
      if (!plan_long_r) full_nxt = first_r;
      down_nxt = first_r;
      en_nxt   = 1'b1;
      wrap_nxt = 1'b0;
    end
    seen_c = wrap_nxt;
    if (ctl.simple && in_cmd == ltt_pkg::OP_POLL) wrap_nxt = 1'b0;
    out_load = ctl.simple || ctl.apply_halt || ctl.apply_plan;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r  <= ltt_pkg::CLOCK_HZ_RST;
      clock_sel_r <= 1'b0;
      irq_en_r    <= 1'b0;
      down_r      <= '0;
      en_r        <= 1'b0;
      long_r      <= 1'b0;
      left_r      <= '0;
      total_r     <= '0;
      first_r     <= '0;
      full_r      <= '0;
      wrap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (ltt_pkg::ltt_reg_t'(cfg_idx))
          ltt_pkg::REG_CLOCK_HZ:  clock_hz_r  <= cfg_data;
          ltt_pkg::REG_CLOCK_SEL: clock_sel_r <= cfg_data[0];
          ltt_pkg::REG_IRQ_EN:    irq_en_r    <= cfg_data[0];
          default: begin
          end
        endcase
      end
      down_r  <= down_nxt;
      en_r    <= en_nxt;
      long_r  <= long_nxt;
      left_r  <= left_nxt;
      total_r <= total_nxt;
      wrap_r  <= wrap_nxt;
      if (ctl.mul_full)  full_r  <= prod[CW-1:0];
      else               full_r  <= full_nxt;
      if (ctl.mul_first) first_r <= prod[CW-1:0];
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start_p) begin
      t_r <= in_time_ms;
      p_r <= p_calc;
    end
    if (ctl.latch_m) begin
      m_r         <= div_quot[CW-1:0];
      plan_long_r <= !sts.t_le_m;
    end
    if (ctl.latch_q) begin
      q_r       <= div_quot;
      rem_seg_r <= div_rem[CW-1:0];
    end
    if (out_load) begin
      count_out_r <= ltt_pkg::COUNT_W'(down_nxt);
      running_r   <= en_nxt;
      seen_r      <= seen_c;
      done_out_r  <= done_c;
      bad_r       <= bad_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_current_count = count_out_r;
  assign out_running       = running_r;
  assign out_wrap_seen     = seen_r;
  assign out_period_done   = done_out_r;
  assign out_status        = bad_r;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for long_interval_tick_timer with a behavioral timer model.
module tb_top;

  localparam logic [31:0] COUNT_MAX = 32'((64'd1 << ltt_pkg::COUNTER_BITS_DEF) - 64'd1);
  localparam logic [ltt_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [ltt_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int PHASE_ITEMS = 380;

  typedef struct packed {
    logic [ltt_pkg::CMD_W-1:0]   cmd;
    logic [ltt_pkg::TIME_W-1:0]  time_ms;
    logic [ltt_pkg::COUNT_W-1:0] count_value;
  } timer_req_t;

  typedef struct packed {
    logic [ltt_pkg::COUNT_W-1:0] count;
    logic                        running;
    logic                        wrap_seen;
    logic                        period_done;
    logic                        status;
  } timer_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_valid = 1'b0;
  timer_req_t                     in_item = '0;
  logic                           out_ready = 1'b0;
  logic                           cfg_valid = 1'b0;
  ltt_pkg::ltt_reg_t              cfg_index = ltt_pkg::REG_CLOCK_HZ;
  logic [ltt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  ltt_in_if  in_req();
  ltt_out_if out_res();
  ltt_cfg_if cfg_wr();

  assign in_req.valid       = in_valid;
  assign in_req.cmd         = in_item.cmd;
  assign in_req.time_ms     = in_item.time_ms;
  assign in_req.count_value = in_item.count_value;
  assign out_res.ready      = out_ready;
  assign cfg_wr.valid       = cfg_valid;
  assign cfg_wr.index       = cfg_index;
  assign cfg_wr.data        = cfg_data;

  long_interval_tick_timer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_res(out_res),
    .cfg_wr (cfg_wr)
  );

  always #5 clk = ~clk;

  // timer model: configuration and state
  logic [ltt_pkg::CLOCK_W-1:0] mdl_hz = ltt_pkg::CLOCK_HZ_RST;
  logic                        mdl_sel = 1'b0;
  logic                        mdl_irq = 1'b0;
  logic [ltt_pkg::COUNT_W-1:0] mdl_count = '0;
  logic                        mdl_on = 1'b0;
  logic                        mdl_long = 1'b0;
  logic [31:0]                 mdl_segs_left = '0;
  logic [31:0]                 mdl_segs_total = '0;
  logic [31:0]                 mdl_first_len = '0;
  logic [31:0]                 mdl_full_len = '0;
  logic                        mdl_wrap = 1'b0;

  timer_req_t  pending[$];
  timer_res_t  expected_results[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_kicks = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          errors = 0;
  int          cycle_count = 0;
  timer_res_t  got_res;
  timer_res_t  want_res;

  function automatic logic [31:0] ticks_per_ms(logic [ltt_pkg::CLOCK_W-1:0] hz, logic sel);
    logic [31:0] src;
    src = sel ? 32'(hz) : 32'(hz >> ltt_pkg::PRESCALE_SHIFT);
    return src / ltt_pkg::MS_PER_S;
  endfunction

  function automatic void stop_timer();
    mdl_on = 1'b0;
    mdl_count = '0;
    mdl_wrap = 1'b0;
  endfunction

  function automatic timer_res_t advance_timer(timer_req_t rq);
    timer_res_t  res;
    logic        done;
    logic        bad;
    logic        seen;
    logic [31:0] p;
    logic [31:0] m;
    logic [31:0] q;
    logic [31:0] rem;
    done = 1'b0;
    bad = 1'b0;
    case (rq.cmd)
      ltt_pkg::OP_TICK: begin
        if (mdl_on) begin
          if (mdl_count > 1) begin
            mdl_count = mdl_count - 1'b1;
          end else begin
            mdl_wrap = 1'b1;
            if (mdl_long && mdl_segs_left != 0) begin
              mdl_segs_left = mdl_segs_left - 1;
              mdl_count = mdl_full_len[ltt_pkg::COUNT_W-1:0];
            end else begin
              mdl_segs_left = mdl_segs_total;
              mdl_count = mdl_first_len[ltt_pkg::COUNT_W-1:0];
              done = mdl_irq;
            end
          end
        end
      end
      ltt_pkg::OP_START: begin
        p = ticks_per_ms(mdl_hz, mdl_sel);
        m = (p == 0) ? 32'd0 : COUNT_MAX / p;
        if (rq.time_ms == 0 || m == 0) begin
          stop_timer();
        end else begin
          mdl_full_len = m * p;
          if (rq.time_ms <= m) begin
            mdl_long = 1'b0;
            mdl_first_len = rq.time_ms * p;
            mdl_full_len = mdl_first_len;
            mdl_segs_total = 0;
          end else begin
            q = rq.time_ms / m;
            rem = rq.time_ms % m;
            mdl_long = 1'b1;
            if (rem != 0) begin
              mdl_first_len = rem * p;
              mdl_segs_total = q;
            end else begin
              mdl_first_len = mdl_full_len;
              mdl_segs_total = q - 1;
            end
          end
          mdl_segs_left = mdl_segs_total;
          mdl_count = mdl_first_len[ltt_pkg::COUNT_W-1:0];
          mdl_on = 1'b1;
          mdl_wrap = 1'b0;
        end
      end
      ltt_pkg::OP_STOP: stop_timer();
      ltt_pkg::OP_WRITE: begin
        if (32'(rq.count_value) > COUNT_MAX) bad = 1'b1;
        else mdl_count = rq.count_value;
        mdl_wrap = 1'b0;
      end
      default: ;
    endcase
    seen = mdl_wrap;
    if (rq.cmd == ltt_pkg::OP_POLL) mdl_wrap = 1'b0;
    res.count = mdl_count;
    res.running = mdl_on;
    res.wrap_seen = seen;
    res.period_done = done;
    res.status = bad;
    return res;
  endfunction

  // mostly tick/write sequences so segments wrap; starts short, random, zero, max or near segment-limit multiples
  function automatic timer_req_t random_req();
    timer_req_t  rq;
    int unsigned pick;
    int unsigned k;
    logic [31:0] lim;
    rq.cmd = ltt_pkg::OP_TICK;
    rq.time_ms = $urandom;
    rq.count_value = ltt_pkg::COUNT_W'($urandom);
    lim = ticks_per_ms(mdl_hz, mdl_sel);
    lim = (lim == 0) ? 32'd1 : COUNT_MAX / lim;
    pick = $urandom_range(99);
    if (pick < 55) begin
      rq.cmd = ltt_pkg::OP_TICK;
    end else if (pick < 72) begin
      rq.cmd = ltt_pkg::OP_WRITE;
      if ($urandom_range(9) < 8) rq.count_value = ltt_pkg::COUNT_W'($urandom_range(5));
    end else if (pick < 82) begin
      rq.cmd = ltt_pkg::OP_POLL;
    end else if (pick < 87) begin
      rq.cmd = ltt_pkg::OP_START;
      k = $urandom_range(9);
      if (k < 3) rq.time_ms = $urandom_range(4, 1);
      else if (k < 7) rq.time_ms = $urandom_range(3, 1) * lim + $urandom_range(2);
      else if (k < 8) rq.time_ms = lim + $urandom_range(1);
      else if (k == 9) rq.time_ms = $urandom_range(1) ? 32'd0 : 32'hFFFF_FFFF;
    end else if (pick < 90) begin
      rq.cmd = ltt_pkg::OP_STOP;
    end else if (pick < 92) begin
      rq.cmd = ltt_pkg::CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    end
    return rq;
  endfunction

  task automatic queue_req(logic [ltt_pkg::CMD_W-1:0] cmd, logic [31:0] t,
                           logic [ltt_pkg::COUNT_W-1:0] cv);
    timer_req_t rq;
    rq.cmd = cmd;
    rq.time_ms = t;
    rq.count_value = cv;
    pending.push_back(rq);
  endtask

  task automatic queue_random(int n);
    @(negedge clk);
    repeat (n) pending.push_back(random_req());
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic write_reg(ltt_pkg::ltt_reg_t idx, logic [ltt_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_wr.ready);
    cfg_valid <= 1'b0;
    case (idx)
      ltt_pkg::REG_CLOCK_HZ:  mdl_hz = val[ltt_pkg::CLOCK_W-1:0];
      ltt_pkg::REG_CLOCK_SEL: mdl_sel = val[0];
      ltt_pkg::REG_IRQ_EN:    mdl_irq = val[0];
      default: ;
    endcase
  endtask

  task automatic run_phase(logic [ltt_pkg::CLOCK_W-1:0] hz, logic sel, logic irq,
                           int idle_pct, int stall_pct, logic with_hold);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(ltt_pkg::REG_CLOCK_HZ, ltt_pkg::CFG_DATA_W'(hz));
    write_reg(ltt_pkg::REG_CLOCK_SEL, ltt_pkg::CFG_DATA_W'(sel));
    write_reg(ltt_pkg::REG_IRQ_EN, ltt_pkg::CFG_DATA_W'(irq));
    @(negedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    queue_random(PHASE_ITEMS / 2);
    if (with_hold) hold_kicks = hold_kicks + 1;
    wait_idle();
    queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_req.ready) expected_results.push_back(advance_timer(in_item));
      if (!in_valid || in_req.ready) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_served != hold_kicks) begin
      hold_served <= hold_kicks;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_res.valid && out_ready) begin
        got_res.count = out_res.current_count;
        got_res.running = out_res.running;
        got_res.wrap_seen = out_res.wrap_seen;
        got_res.period_done = out_res.period_done;
        got_res.status = out_res.status;
        if (expected_results.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("unexpected result: count=%h run=%b wrap=%b done=%b status=%b",
                     got_res.count, got_res.running, got_res.wrap_seen,
                     got_res.period_done, got_res.status);
        end else begin
          want_res = expected_results.pop_front();
          if (got_res.count !== want_res.count || got_res.running !== want_res.running ||
              got_res.wrap_seen !== want_res.wrap_seen ||
              got_res.period_done !== want_res.period_done ||
              got_res.status !== want_res.status) begin
            errors = errors + 1;
            if (errors <= 10) begin
              $display("mismatch: exp count=%h run=%b wrap=%b done=%b status=%b",
                       want_res.count, want_res.running, want_res.wrap_seen,
                       want_res.period_done, want_res.status);
              $display("          got count=%h run=%b wrap=%b done=%b status=%b",
                       got_res.count, got_res.running, got_res.wrap_seen,
                       got_res.period_done, got_res.status);
            end
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // reset config: 2000 ticks/ms, segment limit 8388 ms
    queue_req(ltt_pkg::OP_TICK, 32'd0, 24'd0);
    queue_req(ltt_pkg::OP_POLL, 32'd0, 24'd0);
    queue_req(ltt_pkg::OP_WRITE, 32'd0, 24'hFF_FFFF);
    queue_req(CMD_SPARE_LO, 32'hFFFF_FFFF, 24'hFF_FFFF);
    queue_req(CMD_SPARE_HI, 32'd0, 24'd0);
    queue_req(ltt_pkg::OP_START, 32'd0, 24'd0);
    queue_req(ltt_pkg::OP_START, 32'd1, 24'd0);
    queue_req(ltt_pkg::OP_WRITE, 32'd0, 24'd2);
    queue_req(ltt_pkg::OP_TICK, 32'd0, 24'd0);
    queue_req(ltt_pkg::OP_TICK, 32'd0, 24'd0);
    queue_req(ltt_pkg::OP_POLL, 32'd0, 24'd0);
    queue_req(ltt_pkg::OP_POLL, 32'd0, 24'd0);
    queue_req(ltt_pkg::OP_START, 32'd8388, 24'd0);
    queue_req(ltt_pkg::OP_START, 32'd8389, 24'd0);
    queue_req(ltt_pkg::OP_WRITE, 32'd0, 24'd0);
    queue_req(ltt_pkg::OP_TICK, 32'd0, 24'd0);
    queue_req(ltt_pkg::OP_WRITE, 32'd0, 24'd1);
    queue_req(ltt_pkg::OP_TICK, 32'd0, 24'd0);
    queue_req(ltt_pkg::OP_START, 32'd16776, 24'd0);
    queue_req(ltt_pkg::OP_WRITE, 32'd0, 24'd0);
    queue_req(ltt_pkg::OP_TICK, 32'd0, 24'd0);
    queue_req(ltt_pkg::OP_WRITE, 32'd0, 24'd0);
    queue_req(ltt_pkg::OP_TICK, 32'd0, 24'd0);
    queue_req(ltt_pkg::OP_START, 32'hFFFF_FFFF, 24'd0);
    queue_req(ltt_pkg::OP_STOP, 32'd0, 24'd0);
    queue_req(ltt_pkg::OP_WRITE, 32'd0, 24'd5);
    queue_req(ltt_pkg::OP_TICK, 32'd0, 24'd0);

    run_phase(ltt_pkg::CLOCK_W'(8000), 1'b0, 1'b1, 0, 0, 1'b0);
    run_phase(ltt_pkg::CLOCK_W'(84000000), 1'b1, 1'b1, 84, 0, 1'b0);
    run_phase(ltt_pkg::CLOCK_W'($urandom_range(84000000, 8000)), 1'($urandom_range(1)),
              1'b1, 0, 84, 1'b1);
    run_phase(ltt_pkg::CLOCK_W'(8000), 1'b1, 1'b0, 7, 7, 1'b0);
    run_phase(ltt_pkg::CLOCK_W'(84000000), 1'b0, 1'b1, 0, 0, 1'b1);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
